// ----- sv/rhc_pkg.sv -----
// Shared types and constants for the RGB to HSL converter.
// No dependencies; every design file imports this package.
package rhc_pkg;

    localparam int DIV_STAGES  = 24;
    localparam int DIV_WIDTH   = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [11:0] SECTOR_UNITS = 12'd3840;
    localparam logic [14:0] FULL_TURN    = 15'd23040;
    localparam logic [14:0] HUE_MAX      = 15'd23039;
    localparam logic [8:0]  LIGHT_MAX    = 9'd510;
    localparam logic [15:0] SAT_MAX      = 16'hFFFF;

    // One classified pixel as it waits in the queue.
    typedef struct packed {
        logic [DIV_WIDTH-1:0] hue_num;
        logic [7:0]           hue_den;
        logic                 hue_neg;
        logic [DIV_WIDTH-1:0] sat_num;
        logic [7:0]           sat_den;
        logic [8:0]           lightness;
        logic                 chroma;
    } pixel_word_t;

    // Fields that ride alongside the dividers.
    typedef struct packed {
        logic       valid;
        logic       hue_neg;
        logic [8:0] lightness;
        logic       chroma;
    } side_t;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ----- sv/rgb_to_hsl_converter_core.sv -----
// Top level of the RGB to HSL converter.
// Depends on rhc_pkg, rhc_front, rhc_queue, rhc_back (and rhc_div through it).
//
// Usage: the input channel carries one pixel word (red_in, green_in, blue_in)
// and is taken at a rising edge where in_valid is high and in_stall is low.
// The output channel carries hue_angle (1/64 degree), lightness_twice (max plus
// min) and saturation_frac (Q0.16) and is taken where out_valid is high and
// out_stall is low. Every pixel gives exactly one result word, in order.
// Throughput is one pixel per clock while the receiver does not stall. From
// acceptance to out_valid a word passes the front register, the queue, the 24
// one-bit-per-stage divider stages and the output register, which takes the
// word at the end of the last divider stage.
// After reset deasserts the block is empty and takes a pixel at once;
// no clearing pass is needed since no state is kept between pixels.
// When the receiver stalls, the result holds and the divider pipeline freezes;
// the four-word queue keeps absorbing pixels, and in_stall rises only once the
// queue is full and the front register holds a word as well.
module rgb_to_hsl_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [14:0] hue_angle,
    output logic [8:0]  lightness_twice,
    output logic [15:0] saturation_frac
);
    import rhc_pkg::*;

    queue_stat_t q_stat;
    pixel_word_t push_word, head_word;
    logic        push, pop;

    // Front part: classification and divider operands.
    rhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .q_stat    (q_stat),
        .push      (push),
        .push_word (push_word)
    );

    // The queue lets the front keep accepting while the back is held.
    rhc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .q_stat    (q_stat)
    );

    // Back part: the two dividers and the output register.
    rhc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_word       (head_word),
        .q_stat          (q_stat),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hue_angle       (hue_angle),
        .lightness_twice (lightness_twice),
        .saturation_frac (saturation_frac)
    );

endmodule

// ----- sv/rhc_front.sv -----
// Front part: registers an accepted pixel, finds max, min, the hue sector and the
// divider operands, and pushes the classified word into the queue. Uses rhc_pkg.
module rhc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          red_in,
    input  logic [7:0]          green_in,
    input  logic [7:0]          blue_in,
    input  rhc_pkg::queue_stat_t q_stat,
    output logic                push,
    output rhc_pkg::pixel_word_t push_word
);
    import rhc_pkg::*;

    logic        valid_reg, valid_next;
    pixel_word_t word_reg, word_next;
    logic        load;

    logic [7:0]  mx, mn, diff;
    logic [8:0]  sum;
    logic [11:0] sector_term;
    logic [23:0] product;

    always_comb
    begin
        mx = red_in;
        mn = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx)  mx = blue_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn)  mn = blue_in;
        diff = mx - mn;
        sum  = {1'b0, mx} + {1'b0, mn};

        word_next.hue_neg = 1'b0;
        if (red_in == mx)
        begin
            // Red sector: magnitude of green minus blue, sign kept aside.
            if (green_in < blue_in)
            begin
                sector_term       = {4'b0, blue_in - green_in};
                word_next.hue_neg = 1'b1;
            end
            else
            begin
                sector_term = {4'b0, green_in - blue_in};
            end
        end
        else if (green_in == mx)
        begin
            sector_term = ({4'b0, diff} << 1) + {4'b0, blue_in} - {4'b0, red_in};
        end
        else
        begin
            sector_term = ({4'b0, diff} << 2) + {4'b0, red_in} - {4'b0, green_in};
        end
        product = {12'b0, sector_term} * {12'b0, SECTOR_UNITS};

        word_next.hue_num   = product;
        word_next.hue_den   = diff;
        word_next.sat_num   = {diff, 16'b0};
        word_next.sat_den   = (sum <= 9'd255) ? sum[7:0] : 8'(LIGHT_MAX - sum);
        word_next.lightness = sum;
        word_next.chroma    = (diff != 8'd0);
    end

    assign push     = valid_reg && !q_stat.full;
    assign in_stall = valid_reg && q_stat.full;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= word_next;
    end

    assign push_word = word_reg;

endmodule

// ----- sv/rhc_queue.sv -----
// Short queue that decouples the front part from the divider pipeline.
// Uses rhc_pkg for the word type and depth.
module rhc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rhc_pkg::pixel_word_t push_word,
    input  logic                 pop,
    output rhc_pkg::pixel_word_t head_word,
    output rhc_pkg::queue_stat_t q_stat
);
    import rhc_pkg::*;

    pixel_word_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    assign head_word    = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_WIDTH'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_WIDTH'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow queue");

endmodule

// ----- sv/rhc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, 8-bit divisor.
// Uses rhc_pkg for the stage count and width.
module rhc_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rhc_pkg::DIV_WIDTH-1:0] num,
    input  logic [7:0]                    den,
    output logic [rhc_pkg::DIV_WIDTH-1:0] quo
);
    import rhc_pkg::*;

    logic [DIV_WIDTH-1:0] w_reg   [DIV_STAGES];
    logic [7:0]           rem_reg [DIV_STAGES];
    logic [7:0]           den_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [DIV_WIDTH-1:0] w_in;
            logic [7:0]           rem_in, den_in;
            logic [8:0]           trial;
            logic                 fits;

            if (k == 0)
            begin : g_first
                assign w_in   = num;
                assign rem_in = 8'd0;
                assign den_in = den;
            end
            else
            begin : g_next
                assign w_in   = w_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign trial = {rem_in, w_in[DIV_WIDTH-1]};
            assign fits  = (trial >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    w_reg[k]   <= {w_in[DIV_WIDTH-2:0], fits};
                    rem_reg[k] <= fits ? 8'(trial - {1'b0, den_in}) : trial[7:0];
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = w_reg[DIV_STAGES-1];

endmodule

// ----- sv/rhc_back.sv -----
// Back part: pops classified words, runs the hue and saturation dividers and
// forms the result in the output register. Uses rhc_pkg and rhc_div.
module rhc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rhc_pkg::pixel_word_t head_word,
    input  rhc_pkg::queue_stat_t q_stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [14:0]          hue_angle,
    output logic [8:0]           lightness_twice,
    output logic [15:0]          saturation_frac
);
    import rhc_pkg::*;

    logic                 en;
    logic                 valid_reg;
    side_t                side_reg [DIV_STAGES];
    side_t                side_in, side_last;
    logic [DIV_WIDTH-1:0] hue_q, sat_q;
    logic [14:0]          hue_reg, hue_next;
    logic [8:0]           light_reg;
    logic [15:0]          sat_reg, sat_next;

    // The whole pipeline holds only while a finished result is refused.
    assign en  = !(valid_reg && out_stall);
    assign pop = en && !q_stat.empty;

    assign side_in.valid     = pop;
    assign side_in.hue_neg   = head_word.hue_neg;
    assign side_in.lightness = head_word.lightness;
    assign side_in.chroma    = head_word.chroma;

    rhc_div u_hue_div (
        .clk (clk),
        .en  (en),
        .num (head_word.hue_num),
        .den (head_word.hue_den),
        .quo (hue_q)
    );

    rhc_div u_sat_div (
        .clk (clk),
        .en  (en),
        .num (head_word.sat_num),
        .den (head_word.sat_den),
        .quo (sat_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                side_reg[i] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DIV_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_last = side_reg[DIV_STAGES-1];

    always_comb
    begin
        hue_next = 15'd0;
        sat_next = 16'd0;
        if (side_last.chroma)
        begin
            if (side_last.hue_neg && hue_q != '0)
                hue_next = FULL_TURN - hue_q[14:0];
            else
                hue_next = hue_q[14:0];
            sat_next = (sat_q > DIV_WIDTH'(SAT_MAX)) ? SAT_MAX : sat_q[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= side_last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            light_reg <= side_last.lightness;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid       = valid_reg;
    assign hue_angle       = hue_reg;
    assign lightness_twice = light_reg;
    assign saturation_frac = sat_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> hue_reg <= HUE_MAX)
        else $error("hue out of range");
    a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> light_reg <= LIGHT_MAX)
        else $error("lightness out of range");
    a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && side_last.valid && !side_last.chroma) |=> hue_reg == '0 && sat_reg == '0)
        else $error("achromatic pixel with nonzero hue or saturation");

endmodule

// ----- tb/sv/rgb_to_hsl_converter_core_checker.sv -----
// Checker for the RGB to HSL converter: watches both channels, predicts each
// result word from the accepted pixel and compares field by field.
// Depends only on the port widths of rgb_to_hsl_converter_core.
module rgb_to_hsl_converter_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [14:0] hue_angle,
    input  logic [8:0]  lightness_twice,
    input  logic [15:0] saturation_frac,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [14:0] hue;
        logic [8:0]  light;
        logic [15:0] sat;
    } hsl_word_t;

    hsl_word_t hsl_expected[$];

    initial fail_count = 0;
    assign pending_count = hsl_expected.size();

    function automatic hsl_word_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
        int r, g, b, mx, mn, diff, sum, den, h;
        longint q;
        hsl_word_t w;
        r = int'(r8); g = int'(g8); b = int'(b8);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        diff = mx - mn;
        sum = mx + mn;
        w.light = sum[8:0];
        w.hue = '0;
        w.sat = '0;
        if (diff != 0)
        begin
            // Red wins ties, then green, then blue; division truncates toward zero.
            if (r == mx)
            begin
                h = ((g - b) * 3840) / diff;
                if (h < 0) h += 23040;
            end
            else if (g == mx)
                h = (2 * 3840 * diff + (b - r) * 3840) / diff;
            else
                h = (4 * 3840 * diff + (r - g) * 3840) / diff;
            w.hue = h[14:0];
            den = (sum <= 255) ? sum : 510 - sum;
            if (den != 0)
            begin
                q = (longint'(diff) << 16) / den;
                if (q > 65535) q = 65535;
                w.sat = q[15:0];
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        hsl_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                hsl_expected.push_back(convert_pixel(red_in, green_in, blue_in));
            if (out_valid && !out_stall)
            begin
                if (hsl_expected.size() == 0)
                    report_mismatch("unexpected word", 1, 0);
                else
                begin
                    want = hsl_expected.pop_front();
                    if (hue_angle != want.hue)
                        report_mismatch("hue_angle", int'(hue_angle), int'(want.hue));
                    if (lightness_twice != want.light)
                        report_mismatch("lightness_twice", int'(lightness_twice),
                                        int'(want.light));
                    if (saturation_frac != want.sat)
                        report_mismatch("saturation_frac", int'(saturation_frac),
                                        int'(want.sat));
                end
            end
        end
    end

endmodule

// ----- tb/sv/rgb_to_hsl_converter_core_tb.sv -----
// Testbench top for the RGB to HSL converter: drives pixels and stalls.
// Depends on rgb_to_hsl_converter_core and rgb_to_hsl_converter_core_checker.
module rgb_to_hsl_converter_core_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic        out_valid;
    logic        out_stall;
    logic [14:0] hue_angle;
    logic [8:0]  lightness_twice;
    logic [15:0] saturation_frac;
    int          fail_count;
    int          pending_count;

    // Idle percentage for each side; zero during the calm stretch.
    int          send_idle_pct;
    int          recv_idle_pct;
    // While set, the receiver holds off so the queue fills and in_stall rises.
    bit          hold_off;

    rgb_to_hsl_converter_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .red_in          (red_in),
        .green_in        (green_in),
        .blue_in         (blue_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hue_angle       (hue_angle),
        .lightness_twice (lightness_twice),
        .saturation_frac (saturation_frac)
    );

    rgb_to_hsl_converter_core_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .red_in          (red_in),
        .green_in        (green_in),
        .blue_in         (blue_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hue_angle       (hue_angle),
        .lightness_twice (lightness_twice),
        .saturation_frac (saturation_frac),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    // The clock runs with a period of 20 time units.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sends one pixel word. Valid is held high until the word is taken, and the
    // payload only changes at a falling edge after acceptance, so a stalled
    // word stays put. Random idle cycles are inserted before the word.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random pixel biased toward the interesting regions: grays, ties
    // between channels, and fully saturated colors.
    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        case ($urandom_range(9))
            0: begin g = r; b = r; end
            1: g = r;
            2: b = g;
            3: b = r;
            4: begin r = 8'd255; b = 8'd0; end
            5:
            begin
                r = 8'($urandom_range(3));
                g = 8'($urandom_range(3));
                b = 8'($urandom_range(3));
            end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    // Receiver: stalls at random, or for the whole hold-off window.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // The long hold-off is timed in cycles by a process of its own.
    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (150) @(posedge clk);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (80) @(posedge clk);
        @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        red_in        = '0;
        green_in      = '0;
        blue_in       = '0;
        send_idle_pct = 6;
        recv_idle_pct = 6;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: black, white, grays, primaries, secondaries, ties
        // between channels that test sector priority, the negative red sector,
        // sums either side of the saturation midpoint, and single-bit patterns.
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd200, 8'd10,  8'd100);
        send_pixel(8'd200, 8'd200, 8'd50);
        send_pixel(8'd50,  8'd200, 8'd200);
        send_pixel(8'd128, 8'd127, 8'd0);
        send_pixel(8'd128, 8'd128, 8'd127);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd2);
        send_pixel(8'd170, 8'd85,  8'd170);
        send_pixel(8'd85,  8'd170, 8'd85);
        send_pixel(8'd10,  8'd20,  8'd30);
        send_pixel(8'd240, 8'd230, 8'd245);

        // Random words; a calm stretch in the middle has no idling at all.
        for (int i = 0; i < 800; i++)
        begin
            if (i == 400)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (i == 550)
            begin
                send_idle_pct = 6;
                recv_idle_pct = 6;
            end
            send_random_pixel();
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("rgb_to_hsl_converter_core verification clean");
        else
            $display("rgb_to_hsl_converter_core verification failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("rgb_to_hsl_converter_core verification failed");
        $finish;
    end

endmodule
